@@ rtl/core/utw_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 text line wrapper package
// Shared codes, byte constants and the result list carried from the wrap
// core to the result buffer.
// ----------------------------------------------------------------------------
package utw_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROWS     = 2'd1;

  localparam int unsigned WRAP_COLUMNS_RESET = 40;
  localparam int unsigned MAX_ROWS_RESET     = 4;

  // Byte values that steer the decode
  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CONT  = 8'h80;
  localparam logic [7:0] BYTE_LEAD2 = 8'hC2;
  localparam logic [7:0] BYTE_LEAD3 = 8'hE0;
  localparam logic [7:0] BYTE_LEAD4 = 8'hF0;
  localparam logic [7:0] BYTE_LEAD5 = 8'hF8;
  localparam logic [7:0] BYTE_LEAD6 = 8'hFC;
  localparam logic [7:0] BYTE_LONE  = 8'hFE;

  // At most four results per input byte: one text or error byte and three breaks
  localparam int unsigned RES_MAX   = 4;
  localparam int unsigned RES_CNT_W = 3;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_BREAK = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      out_kind;
    logic       halted;
  } res_ent_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]     cnt;
    res_ent_t [RES_MAX-1:0]   ent;
  } res_list_t;

  // Sequence length in bytes of a valid lead byte
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (b < BYTE_CONT) begin
      len = 3'd1;
    end else if (b < BYTE_LEAD3) begin
      len = 3'd2;
    end else if (b < BYTE_LEAD4) begin
      len = 3'd3;
    end else if (b < BYTE_LEAD5) begin
      len = 3'd4;
    end else if (b < BYTE_LEAD6) begin
      len = 3'd5;
    end else if (b < BYTE_LONE) begin
      len = 3'd6;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

endpackage

@@ rtl/core/utw_if.sv @@
// ----------------------------------------------------------------------------
// UTF-8 text line wrapper channels
// Valid/ready channels for the text input, the result output and the
// configuration write port.
// ----------------------------------------------------------------------------
interface utw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface utw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       run_last;
  logic       halted;

  modport source (output valid, output out_byte, output out_kind, output run_last,
                  output halted, input ready);
  modport sink   (input valid, input out_byte, input out_kind, input run_last,
                  input halted, output ready);
endinterface

interface utw_cfg_if #(
  parameter int unsigned DATA_W = 10
);
  logic                          valid;
  logic                          ready;
  logic [utw_pkg::CFG_IDX_W-1:0] reg_idx;
  logic [DATA_W-1:0]             wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

@@ rtl/core/utw_wrap_core.sv @@
// ----------------------------------------------------------------------------
// UTF-8 wrap core
// Input register, line and chunk state, and the single-pass decode that
// turns one byte into its list of results.
// ----------------------------------------------------------------------------
module utw_wrap_core #(
  parameter int unsigned COLUMN_BITS = 10,
  parameter int unsigned ROW_BITS    = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             in_byte_i,
  input  logic                   in_last_i,
  input  logic [COLUMN_BITS-1:0] wrap_cols_i,
  input  logic [ROW_BITS-1:0]    max_rows_i,
  input  logic                   buf_free_i,
  output logic                   load_o,
  output utw_pkg::res_list_t     list_o
);

  localparam int unsigned OFF_W = COLUMN_BITS + 1;

  logic                 valid_q;
  logic [7:0]           byte_q;
  logic                 last_q;
  logic [OFF_W-1:0]     off_q, off_d;
  logic [ROW_BITS-1:0]  rows_q, rows_d;
  logic [2:0]           btc_q, btc_d;
  logic                 stop_q, stop_d;

  logic                        adv;
  logic [OFF_W-1:0]            cols;
  logic [OFF_W-1:0]            off;
  logic [ROW_BITS-1:0]         rows;
  logic [2:0]                  btc;
  logic                        stop;
  logic                        close_req;
  logic                        ends;
  logic [utw_pkg::RES_CNT_W-1:0] n;
  utw_pkg::res_list_t          lst;

  always_comb begin
    cols = (wrap_cols_i == '0) ? OFF_W'(1) : {1'b0, wrap_cols_i};
    off  = off_q;
    rows = rows_q;
    btc  = btc_q;
    stop = stop_q;
    lst  = '0;
    n    = '0;
    close_req = 1'b0;
    ends = !stop_q && ((byte_q == utw_pkg::BYTE_LF) || last_q);

    if (!stop_q && (byte_q != utw_pkg::BYTE_LF)) begin
      priority if (btc != '0) begin
        lst.ent[n[1:0]] = '{out_byte: byte_q, out_kind: utw_pkg::KIND_TEXT, halted: 1'b0};
        n = n + 1'b1;
        btc = btc - 3'd1;
        close_req = (btc == '0);
      end else if ((byte_q == utw_pkg::BYTE_NUL) ||
                   ((byte_q >= utw_pkg::BYTE_CONT) && (byte_q < utw_pkg::BYTE_LEAD2))) begin
        stop = 1'b1;
        lst.ent[n[1:0]] = '{out_byte: 8'h00, out_kind: utw_pkg::KIND_ERROR, halted: 1'b1};
        n = n + 1'b1;
      end else begin
        lst.ent[n[1:0]] = '{out_byte: byte_q, out_kind: utw_pkg::KIND_TEXT, halted: 1'b0};
        n = n + 1'b1;
        off = off + ((byte_q < utw_pkg::BYTE_CONT) ? OFF_W'(1) : OFF_W'(2));
        btc = utw_pkg::seq_len(byte_q) - 3'd1;
        close_req = (btc == '0);
      end
    end

    // Ending the line completes a partial character
    if (ends && (btc != '0)) begin
      btc = '0;
      close_req = 1'b1;
    end

    // Close up to two chunk edges reached by the finished character
    if (close_req) begin
      for (int k = 0; k < 2; k++) begin
        if (!stop && (off >= cols)) begin
          rows = rows + 1'b1;
          if (rows >= max_rows_i) begin
            stop = 1'b1;
          end
          lst.ent[n[1:0]] = '{out_byte: utw_pkg::BYTE_LF, out_kind: utw_pkg::KIND_BREAK,
                              halted: stop};
          n = n + 1'b1;
          off = off - cols;
        end
      end
      if (off >= cols) begin
        off = cols - OFF_W'(1);
      end
    end

    // Break after a partly filled chunk at the end of the line
    if (ends) begin
      if ((off != '0) && !stop) begin
        rows = rows + 1'b1;
        if (rows >= max_rows_i) begin
          stop = 1'b1;
        end
        lst.ent[n[1:0]] = '{out_byte: utw_pkg::BYTE_LF, out_kind: utw_pkg::KIND_BREAK,
                            halted: stop};
        n = n + 1'b1;
      end
      off = '0;
    end

    lst.cnt = n;

    off_d  = last_q ? '0 : off;
    rows_d = last_q ? '0 : rows;
    btc_d  = last_q ? '0 : btc;
    stop_d = last_q ? 1'b0 : stop;
  end

  // A byte with no result leaves without waiting for the buffer
  assign adv        = valid_q && ((lst.cnt == '0) || buf_free_i);
  assign in_ready_o = !valid_q || adv;
  assign load_o     = adv && (lst.cnt != '0);
  assign list_o     = lst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      off_q   <= '0;
      rows_q  <= '0;
      btc_q   <= '0;
      stop_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (adv) begin
        off_q  <= off_d;
        rows_q <= rows_d;
        btc_q  <= btc_d;
        stop_q <= stop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

endmodule

@@ rtl/core/utw_result_buf.sv @@
// ----------------------------------------------------------------------------
// UTF-8 wrap result buffer
// Holds the results of one byte and hands them out one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module utw_result_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  utw_pkg::res_list_t list_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic [1:0]         out_kind_o,
  output logic               run_last_o,
  output logic               halted_o
);

  logic [utw_pkg::RES_CNT_W-1:0]        cnt_q;
  utw_pkg::res_ent_t [utw_pkg::RES_MAX-1:0] ent_q;
  logic                                 take;

  assign take        = (cnt_q != '0) && out_ready_i;
  assign free_o      = (cnt_q == '0) || ((cnt_q == utw_pkg::RES_CNT_W'(1)) && out_ready_i);
  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = ent_q[0].out_byte;
  assign out_kind_o  = ent_q[0].out_kind;
  assign halted_o    = ent_q[0].halted;
  assign run_last_o  = (cnt_q == utw_pkg::RES_CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= list_i.cnt;
    end else if (take) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= list_i.ent;
    end else if (take) begin
      for (int i = 0; i < utw_pkg::RES_MAX - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
    end
  end

endmodule

@@ rtl/core/utf8_text_line_wrapper.sv @@
// Throughput: one byte per cycle while each byte gives at most one result
//   and the output is ready; a byte with more results (up to four) holds
//   the input until its last result leaves the result buffer, which drains
//   one result per cycle while the output is ready.
// Reset: clears line state, row count and halt flag; wrap_columns returns to
//   40 and max_rows to 4.
// ----------------------------------------------------------------------------
// UTF-8 text line wrapper
// Wraps each source line of UTF-8 text into fixed-width chunks, inserting a
// line break after every chunk and halting after a row limit or a bad lead.
// ----------------------------------------------------------------------------
module utf8_text_line_wrapper #(
  parameter int unsigned COLUMN_BITS = 10,
  parameter int unsigned ROW_BITS    = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  utw_cfg_if.sink   cfg_i,
  utw_in_if.sink    in_i,
  utw_out_if.source out_o
);

  // Configuration registers; a write to an unknown index is taken and dropped
  logic [COLUMN_BITS-1:0] wrap_cols_q;
  logic [ROW_BITS-1:0]    max_rows_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_cols_q <= COLUMN_BITS'(utw_pkg::WRAP_COLUMNS_RESET);
      max_rows_q  <= ROW_BITS'(utw_pkg::MAX_ROWS_RESET);
    end else if (cfg_i.valid) begin
      if (cfg_i.reg_idx == utw_pkg::REG_WRAP_COLUMNS) begin
        wrap_cols_q <= cfg_i.wdata[COLUMN_BITS-1:0];
      end
      if (cfg_i.reg_idx == utw_pkg::REG_MAX_ROWS) begin
        max_rows_q <= cfg_i.wdata[ROW_BITS-1:0];
      end
    end
  end

  // Decode each request in one pass and hand its result list to the buffer
  logic               buf_free;
  logic               load;
  utw_pkg::res_list_t list;

  utw_wrap_core #(
    .COLUMN_BITS(COLUMN_BITS),
    .ROW_BITS   (ROW_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_byte_i  (in_i.in_byte),
    .in_last_i  (in_i.in_last),
    .wrap_cols_i(wrap_cols_q),
    .max_rows_i (max_rows_q),
    .buf_free_i (buf_free),
    .load_o     (load),
    .list_o     (list)
  );

  // Results leave from registers; the buffer reloads in the cycle it drains
  utw_result_buf u_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .list_i     (list),
    .free_o     (buf_free),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_byte_o (out_o.out_byte),
    .out_kind_o (out_o.out_kind),
    .run_last_o (out_o.run_last),
    .halted_o   (out_o.halted)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 text line wrapper testbench
// Streams UTF-8 text through the wrapper under a series of chunk widths and
// row limits, predicts every result byte, break and error, and compares the
// results in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned COLUMN_BITS   = 10;
  localparam int unsigned ROW_BITS      = 8;
  localparam int unsigned TOTAL_ITEMS   = 220;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_COUNT   = 10;
  localparam longint     TIMEOUT_NS     = 20_000_000;
  localparam logic [7:0] CONT_MAX       = 8'hBF;

  // One expected result of the wrapper
  typedef struct {
    logic [7:0]     data;
    utw_pkg::kind_e kind;
    logic           run_last;
    logic           halted;
  } wrap_res_t;

  typedef enum int unsigned {
    RX_STEADY,
    RX_CHOPPY,
    RX_STALLS
  } rx_mode_e;

  // --------------------------------------------------------------------------
  // Wrap predictor and store of expected results. Each accepted byte runs
  // through the line state below; the results it causes queue up in order.
  // --------------------------------------------------------------------------
  class wrap_scoreboard;
    logic [COLUMN_BITS-1:0] wrap_cols;
    logic [ROW_BITS-1:0]    row_limit;
    int unsigned            cells_used;
    logic [ROW_BITS-1:0]    rows_done;
    int unsigned            cont_left;
    bit                     halt;
    wrap_res_t              step_res[$];
    wrap_res_t              expected_q[$];
    int                     errors;

    function new();
      wrap_cols  = COLUMN_BITS'(utw_pkg::WRAP_COLUMNS_RESET);
      row_limit  = ROW_BITS'(utw_pkg::MAX_ROWS_RESET);
      errors     = 0;
      clear_text();
    endfunction

    static function int unsigned lead_len(logic [7:0] b);
      if (b < utw_pkg::BYTE_CONT) return 1;
      if (b < utw_pkg::BYTE_LEAD3) return 2;
      if (b < utw_pkg::BYTE_LEAD4) return 3;
      if (b < utw_pkg::BYTE_LEAD5) return 4;
      if (b < utw_pkg::BYTE_LEAD6) return 5;
      if (b < utw_pkg::BYTE_LONE) return 6;
      return 1;
    endfunction

    function void clear_text();
      cells_used = 0;
      rows_done  = '0;
      cont_left  = 0;
      halt       = 1'b0;
    endfunction

    function void add_res(logic [7:0] d, utw_pkg::kind_e k);
      wrap_res_t r;
      if (step_res.size() >= 5) return;
      r.data     = d;
      r.kind     = k;
      r.run_last = 1'b0;
      r.halted   = halt;
      step_res.push_back(r);
    endfunction

    function int unsigned chunk_width();
      return (wrap_cols == 0) ? 1 : int'(wrap_cols);
    endfunction

    function void put_break();
      if (halt) return;
      rows_done = rows_done + 1'b1;
      if (rows_done >= row_limit) halt = 1'b1;
      add_res(utw_pkg::BYTE_LF, utw_pkg::KIND_BREAK);
    endfunction

    // A character is complete: close up to two chunk edges, clamp the rest
    function void finish_char();
      int unsigned c;
      c = chunk_width();
      repeat (2) begin
        if (!halt && cells_used >= c) begin
          put_break();
          cells_used -= c;
        end
      end
      if (cells_used >= c) cells_used = c - 1;
    endfunction

    function void close_line();
      if (cont_left != 0) begin
        cont_left = 0;
        finish_char();
      end
      if (cells_used != 0) put_break();
      cells_used = 0;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      wrap_res_t r;
      step_res.delete();
      if (!halt) begin
        if (b == utw_pkg::BYTE_LF) begin
          close_line();
        end else if (cont_left != 0) begin
          add_res(b, utw_pkg::KIND_TEXT);
          cont_left--;
          if (cont_left == 0) finish_char();
        end else if (b == utw_pkg::BYTE_NUL ||
                     (b >= utw_pkg::BYTE_CONT && b < utw_pkg::BYTE_LEAD2)) begin
          halt = 1'b1;
          add_res(utw_pkg::BYTE_NUL, utw_pkg::KIND_ERROR);
        end else begin
          add_res(b, utw_pkg::KIND_TEXT);
          cells_used += (b < utw_pkg::BYTE_CONT) ? 1 : 2;
          cont_left = lead_len(b) - 1;
          if (cont_left == 0) finish_char();
        end
        if (last && !halt) close_line();
      end
      if (last) clear_text();
      if (step_res.size() != 0) begin
        r = step_res.pop_back();
        r.run_last = 1'b1;
        step_res.push_back(r);
      end
      foreach (step_res[i]) expected_q.push_back(step_res[i]);
    endfunction

    function void check_result(logic [7:0] d, logic [1:0] k, logic rl, logic h);
      wrap_res_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: out_byte=%02h out_kind=%0d", d, k);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (d !== e.data) begin
        $error("out_byte: expected %02h, got %02h", e.data, d);
        errors++;
      end
      if (k !== e.kind) begin
        $error("out_kind: expected %0d, got %0d", e.kind, k);
        errors++;
      end
      if (rl !== e.run_last) begin
        $error("run_last: expected %0b, got %0b", e.run_last, rl);
        errors++;
      end
      if (h !== e.halted) begin
        $error("halted: expected %0b, got %0b", e.halted, h);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  utw_in_if                         in_if();
  utw_out_if                        out_if();
  utw_cfg_if #(.DATA_W(COLUMN_BITS)) cfg_if();

  utf8_text_line_wrapper #(
    .COLUMN_BITS(COLUMN_BITS),
    .ROW_BITS   (ROW_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  wrap_scoreboard sb;
  logic [8:0]     text_q[$];   // {in_last, in_byte} waiting to be sent
  bit             no_gaps;
  rx_mode_e       rx_mode;
  int unsigned    rx_mode_left;
  int unsigned    stall_left;
  int unsigned    sent_bytes;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops a result
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result sink: switch at random between always ready, choppy ready and long
  // stalls so that stalls hit every phase of the work.
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(16, 96);
    end else begin
      rx_mode_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: begin
          out_if.ready <= 1'b1;
        end
        RX_CHOPPY: begin
          out_if.ready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(8, 40);
            out_if.ready <= 1'b0;
          end else begin
            out_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Monitor: check results first, then predict from the byte taken at the
  // same edge; its results can only show up at later edges.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.out_byte, out_if.out_kind, out_if.run_last, out_if.halted);
      end
      if (in_if.valid && in_if.ready) begin
        sb.note_byte(in_if.in_byte, in_if.in_last);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    text_q.push_back({last, b});
  endtask

  // Hold the sender until every predicted result is out, then let the block
  // settle so that bytes without results have surely passed through.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Drop valid for a random gap: mostly none or short, now and then long
  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    if (no_gaps) return;
    r = $urandom_range(0, 99);
    if (r < 60) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n != 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Send every queued byte; valid stays high across back-to-back requests
  task automatic send_text_bytes();
    logic [8:0] item;
    while (text_q.size() != 0) begin
      item = text_q.pop_front();
      if ($urandom_range(0, 59) == 0) drain_results();
      idle_gap();
      in_if.valid   <= 1'b1;
      in_if.in_byte <= item[7:0];
      in_if.in_last <= item[8];
      do @(posedge clk_i); while (!in_if.ready);
      sent_bytes++;
    end
  endtask

  task automatic write_reg(input logic [utw_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    cfg_if.valid   <= 1'b1;
    cfg_if.reg_idx <= idx;
    cfg_if.wdata   <= COLUMN_BITS'(val);
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Write both registers while idle and mirror them in the predictor
  task automatic set_config(input int unsigned cols, input int unsigned rows);
    write_reg(utw_pkg::REG_WRAP_COLUMNS, cols);
    sb.wrap_cols = COLUMN_BITS'(cols);
    write_reg(utw_pkg::REG_MAX_ROWS, rows);
    sb.row_limit = ROW_BITS'(rows);
    cfg_if.valid <= 1'b0;
  endtask

  // Queue one character: ASCII, a newline, a multi-byte sequence, or with
  // noise on, a bad lead or a sequence cut short.
  task automatic queue_char(input bit noisy);
    int unsigned r;
    int unsigned n_cont;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (noisy && r < 8) begin
      if ($urandom_range(0, 3) == 0) b = utw_pkg::BYTE_NUL;
      else b = 8'($urandom_range(utw_pkg::BYTE_CONT, utw_pkg::BYTE_LEAD2 - 1));
      push_byte(b, 1'b0);
    end else if (r < 14) begin
      push_byte(utw_pkg::BYTE_LF, 1'b0);
    end else if (r < 55) begin
      b = 8'($urandom_range(1, 126));
      if (b >= utw_pkg::BYTE_LF) b++;
      push_byte(b, 1'b0);
    end else begin
      b = 8'($urandom_range(utw_pkg::BYTE_LEAD2, 255));
      push_byte(b, 1'b0);
      n_cont = wrap_scoreboard::lead_len(b) - 1;
      if (noisy && $urandom_range(0, 2) == 0) n_cont = $urandom_range(0, n_cont);
      repeat (n_cont) begin
        // Continuation bytes are copied whatever they hold; a newline among
        // them ends the line early.
        if ($urandom_range(0, 9) == 0) b = 8'($urandom);
        else b = 8'($urandom_range(utw_pkg::BYTE_CONT, CONT_MAX));
        push_byte(b, 1'b0);
      end
    end
  endtask

  // Queue a text of random characters; flag its final byte unless the text
  // is to run on into the next configuration.
  task automatic queue_text(input bit noisy, input bit open_end);
    int unsigned n_chars;
    logic [8:0]  tail;
    if ($urandom_range(0, 5) == 0) n_chars = $urandom_range(13, 60);
    else n_chars = $urandom_range(1, 12);
    repeat (n_chars) queue_char(noisy);
    if (!open_end) begin
      tail = text_q.pop_back();
      tail[8] = 1'b1;
      text_q.push_back(tail);
    end
  endtask

  task automatic queue_directed();
    // Narrow ASCII at both ends, then lone wide bytes that cross edges
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'hFF, 1'b0);
    // Two-byte character, then a three-byte one cut off by a newline with
    // a NUL copied as a continuation byte
    push_byte(8'hDF, 1'b0);
    push_byte(CONT_MAX, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(utw_pkg::BYTE_NUL, 1'b0);
    push_byte(utw_pkg::BYTE_LF, 1'b0);
    // Empty line gives nothing
    push_byte(utw_pkg::BYTE_LF, 1'b0);
    // Six-byte sequence with odd continuation values
    push_byte(8'hFD, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(CONT_MAX, 1'b0);
    // Bad lead halts; the ignored final byte still clears the text
    push_byte(8'(utw_pkg::BYTE_LEAD2 - 8'd1), 1'b0);
    push_byte(8'h41, 1'b1);
    // NUL as the final byte, then the lowest bad lead
    push_byte(utw_pkg::BYTE_NUL, 1'b1);
    push_byte(utw_pkg::BYTE_CONT, 1'b0);
    push_byte(8'h20, 1'b1);
  endtask

  initial begin
    int unsigned cols_tab[PHASE_COUNT] = '{1, 1023, 2, 0, 5, 1023, 3, 8, 1, 17};
    int unsigned rows_tab[PHASE_COUNT] = '{255, 1, 255, 255, 0, 255, 2, 255, 3, 255};
    int unsigned phase;
    int unsigned cols;
    int unsigned rows;
    int unsigned n_texts;

    sb = new();
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.in_byte  <= '0;
    in_if.in_last  <= 1'b0;
    cfg_if.valid   <= 1'b0;
    cfg_if.reg_idx <= utw_pkg::REG_WRAP_COLUMNS;
    cfg_if.wdata   <= '0;
    no_gaps    = 1'b0;
    sent_bytes = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Run a few texts on the reset settings first
    repeat (3) begin
      queue_text(1'b0, 1'b0);
      send_text_bytes();
    end
    drain_results();

    // Directed bytes on a three-cell chunk
    set_config(3, 255);
    queue_directed();
    send_text_bytes();
    drain_results();

    // One-cell chunks with a row limit of two: the rest of the text is ignored
    set_config(1, 2);
    push_byte(8'h41, 1'b0);
    push_byte(8'h42, 1'b0);
    push_byte(8'h43, 1'b0);
    push_byte(8'h44, 1'b1);
    send_text_bytes();
    drain_results();

    // Random phases: fixed corner settings first with one text each, then
    // random ones. A phase may leave its last line open so that the next
    // width applies mid-line. Stop once the byte budget is spent.
    phase = 0;
    while (sent_bytes < TOTAL_ITEMS) begin
      if (phase < PHASE_COUNT) begin
        cols = cols_tab[phase];
        rows = rows_tab[phase];
      end else begin
        cols = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 12);
        rows = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 255);
      end
      set_config(cols, rows);
      n_texts = (phase < PHASE_COUNT) ? 1 : $urandom_range(3, 6);
      for (int t = 0; t < n_texts; t++) begin
        if (sent_bytes >= TOTAL_ITEMS) break;
        no_gaps = ($urandom_range(0, 3) == 0);
        queue_text($urandom_range(0, 4) == 0,
                   (t == n_texts - 1) && ($urandom_range(0, 2) == 0));
        send_text_bytes();
      end
      no_gaps = 1'b0;
      drain_results();
      phase++;
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/utw_pkg.sv
rtl/core/utw_if.sv
rtl/core/utw_wrap_core.sv
rtl/core/utw_result_buf.sv
rtl/core/utf8_text_line_wrapper.sv
tb/tb_top.sv
